// ===== hw/rtl/arpc_pkg.sv =====
// ============================================================================
// arpc_pkg
// Shared types and constants for the ARP cache and responder.
// ============================================================================
package arpc_pkg;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // front-to-back queue depth (power of two)
    localparam int QUEUE_DEPTH = 2;

    // APB port geometry: two registers on 8-byte spacing
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    // header checks
    localparam logic [15:0] MIN_PKT_LEN    = 16'd28;
    localparam logic [15:0] HW_ETHERNET    = 16'd1;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  ADDR_HW_LEN    = 8'd6;
    localparam logic [7:0]  ADDR_PROTO_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST     = 16'd1;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // table entry layout: {ip, mac}
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    typedef enum logic [1:0] {
        PS_OK      = 2'd0,
        PS_SHORT   = 2'd1,
        PS_BAD_HDR = 2'd2
    } pkt_status_t;

    typedef enum logic [2:0] {
        CA_NONE        = 3'd0,
        CA_MATCH_SAME  = 3'd1,
        CA_MAC_CHANGED = 3'd2,
        CA_INSERTED    = 3'd3,
        CA_EVICTED     = 3'd4
    } cache_action_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic              is_lookup;
        pkt_status_t       status;
        logic              learn;
        logic              reply;
        logic [IP_W-1:0]   key_ip;
        logic [MAC_W-1:0]  mac;
    } arpc_item_t;

endpackage

// ===== hw/rtl/arp_cache_responder.sv =====
// ============================================================================
// arp_cache_responder
// ARP cache with learn/refresh, reply indication and address lookup.
// ============================================================================
// Every transaction gives exactly one result. A front stage checks the
// header (length, then hardware/protocol type and address lengths), decides
// whether the sender mapping is learned and whether a reply to own_ip is
// due, and hands the classified transaction through a two-deep queue to the
// back stage. The back stage scans the table one entry per cycle through a
// registered-read RAM, keeping the lowest valid match and the lowest free
// slot, then refreshes, inserts or overwrites slot 0 when full. Lookups and
// learning packets read every table entry through the single read port;
// dropped packets and packets with a zero sender IP skip the scan. The
// back stage handles one transaction at a time, and a stalled result
// holds it until the result is taken. Entry valid bits are flip-flops
// cleared at reset, so the table is usable right away with
// no clearing pass. own_ip sits at byte address 0 and own_mac at 8 on the
// 64-bit APB port; write them only while no transaction is in flight.
// ============================================================================
module arp_cache_responder #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [arpc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [arpc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [arpc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // input transactions
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [15:0]                      pkt_len,
    input  logic [15:0]                      hw_type,
    input  logic [15:0]                      ptype,
    input  logic [7:0]                       hw_len,
    input  logic [7:0]                       plen,
    input  logic [15:0]                      operation,
    input  logic [47:0]                      src_mac,
    input  logic [31:0]                      src_ip,
    input  logic [31:0]                      tgt_ip,
    input  logic [31:0]                      lookup_ip,
    // result transactions
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       packet_status,
    output logic [2:0]                       cache_action,
    output logic                             send_reply,
    output logic [47:0]                      reply_mac,
    output logic [31:0]                      reply_ip,
    output logic                             lookup_hit,
    output logic [47:0]                      lookup_mac
);

    arpc_pkg::arpc_item_t push_item;
    arpc_pkg::arpc_item_t head_item;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;

    // front: config registers and classification
    arpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .pkt_len    (pkt_len),
        .hw_type    (hw_type),
        .ptype      (ptype),
        .hw_len     (hw_len),
        .plen       (plen),
        .operation  (operation),
        .src_mac    (src_mac),
        .src_ip     (src_ip),
        .tgt_ip     (tgt_ip),
        .lookup_ip  (lookup_ip),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    // decouples acceptance from the table scan
    arpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    // back: table scan, update and result register
    arpc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_status (packet_status),
        .cache_action  (cache_action),
        .send_reply    (send_reply),
        .reply_mac     (reply_mac),
        .reply_ip      (reply_ip),
        .lookup_hit    (lookup_hit),
        .lookup_mac    (lookup_mac)
    );

endmodule

// ===== hw/rtl/arpc_ram.sv =====
// ============================================================================
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/arpc_front.sv =====
// ============================================================================
// arpc_front
// Config registers, input acceptance and packet classification.
// ============================================================================
module arpc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [arpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [arpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [arpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [15:0]                         pkt_len,
    input  logic [15:0]                         hw_type,
    input  logic [15:0]                         ptype,
    input  logic [7:0]                          hw_len,
    input  logic [7:0]                          plen,
    input  logic [15:0]                         operation,
    input  logic [47:0]                         src_mac,
    input  logic [31:0]                         src_ip,
    input  logic [31:0]                         tgt_ip,
    input  logic [31:0]                         lookup_ip,
    // queue side
    input  logic                                q_full,
    output logic                                q_push,
    output arpc_pkg::arpc_item_t                q_item
);

    logic [31:0] own_ip_reg;
    logic [31:0] own_ip_next;
    logic [47:0] own_mac_reg;
    logic [47:0] own_mac_next;

    logic cfg_wr;
    logic is_short;
    logic bad_hdr;
    logic hdr_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        own_ip_next  = own_ip_reg;
        own_mac_next = own_mac_reg;
        if (cfg_wr)
        begin
            if (paddr[arpc_pkg::REG_SEL_BIT] == arpc_pkg::REG_OWN_IP)
            begin
                own_ip_next = pwdata[31:0];
            end
            else
            begin
                own_mac_next = pwdata[47:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else
        begin
            own_ip_reg  <= own_ip_next;
            own_mac_reg <= own_mac_next;
        end
    end

    assign prdata = (paddr[arpc_pkg::REG_SEL_BIT] == arpc_pkg::REG_OWN_MAC)
                  ? {16'd0, own_mac_reg} : {32'd0, own_ip_reg};

    // classification
    assign is_short = pkt_len < arpc_pkg::MIN_PKT_LEN;
    assign bad_hdr  = (hw_type != arpc_pkg::HW_ETHERNET) ||
                      (ptype != arpc_pkg::PROTO_IPV4) ||
                      (hw_len != arpc_pkg::ADDR_HW_LEN) ||
                      (plen != arpc_pkg::ADDR_PROTO_LEN);
    assign hdr_ok   = (func == arpc_pkg::FUNC_PACKET) && !is_short && !bad_hdr;

    always_comb
    begin
        q_item.is_lookup = (func == arpc_pkg::FUNC_LOOKUP);
        if (func == arpc_pkg::FUNC_LOOKUP)
        begin
            q_item.status = arpc_pkg::PS_OK;
        end
        else if (is_short)
        begin
            q_item.status = arpc_pkg::PS_SHORT;
        end
        else if (bad_hdr)
        begin
            q_item.status = arpc_pkg::PS_BAD_HDR;
        end
        else
        begin
            q_item.status = arpc_pkg::PS_OK;
        end
        q_item.learn  = hdr_ok && (src_ip != 32'd0);
        q_item.reply  = hdr_ok && (operation == arpc_pkg::OP_REQUEST) &&
                        (tgt_ip == own_ip_reg);
        q_item.key_ip = (func == arpc_pkg::FUNC_LOOKUP) ? lookup_ip : src_ip;
        q_item.mac    = src_mac;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/arpc_queue.sv =====
// ============================================================================
// arpc_queue
// Short FIFO of classified transactions between front and back.
// ============================================================================
module arpc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  arpc_pkg::arpc_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output arpc_pkg::arpc_item_t  head_item,
    output logic                  empty
);

    localparam int PTR_W = (arpc_pkg::QUEUE_DEPTH > 1) ? $clog2(arpc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(arpc_pkg::QUEUE_DEPTH + 1);

    arpc_pkg::arpc_item_t slot_reg [arpc_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(arpc_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(arpc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(arpc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/arpc_back.sv =====
// ============================================================================
// arpc_back
// Table scan, learn/update and result register.
// ============================================================================
module arpc_back #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // queue side
    input  logic                  q_empty,
    input  arpc_pkg::arpc_item_t  q_item,
    output logic                  q_pop,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            packet_status,
    output logic [2:0]            cache_action,
    output logic                  send_reply,
    output logic [47:0]           reply_mac,
    output logic [31:0]           reply_ip,
    output logic                  lookup_hit,
    output logic [47:0]           lookup_mac
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_OUT    = 4'b1000
    } back_state_t;

    back_state_t st_reg, st_next;
    arpc_pkg::arpc_item_t item_reg, item_next;
    arpc_pkg::cache_action_t action_reg, action_next;

    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [47:0]        match_mac_reg, match_mac_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic               out_valid_reg, out_valid_next;
    arpc_pkg::pkt_status_t   packet_status_reg, packet_status_next;
    arpc_pkg::cache_action_t cache_action_reg, cache_action_next;
    logic               send_reply_reg, send_reply_next;
    logic [47:0]        reply_mac_reg, reply_mac_next;
    logic [31:0]        reply_ip_reg, reply_ip_next;
    logic               lookup_hit_reg, lookup_hit_next;
    logic [47:0]        lookup_mac_reg, lookup_mac_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [arpc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [arpc_pkg::ENTRY_W-1:0] ram_rdata;
    logic [31:0]                  rd_ip;
    logic [47:0]                  rd_mac;
    logic                         issue;
    logic                         cmp_hit;
    logic                         cmp_free;

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_ip    = ram_rdata[arpc_pkg::ENTRY_W-1:arpc_pkg::MAC_W];
    assign rd_mac   = ram_rdata[arpc_pkg::MAC_W-1:0];
    assign issue    = (st_reg == S_SCAN) && (issue_cnt_reg < CNT_W'(TABLE_ENTRIES));
    assign cmp_hit  = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_ip == item_reg.key_ip);
    assign cmp_free = cmp_valid_reg && !valid_reg[cmp_idx_reg];
    assign ram_wdata = {item_reg.key_ip, item_reg.mac};

    always_comb
    begin
        st_next            = st_reg;
        item_next          = item_reg;
        action_next        = action_reg;
        issue_cnt_next     = issue_cnt_reg;
        cmp_valid_next     = 1'b0;
        cmp_idx_next       = cmp_idx_reg;
        found_next         = found_reg;
        match_idx_next     = match_idx_reg;
        match_mac_next     = match_mac_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        valid_next         = valid_reg;
        out_valid_next     = out_valid_reg && out_stall;
        packet_status_next = packet_status_reg;
        cache_action_next  = cache_action_reg;
        send_reply_next    = send_reply_reg;
        reply_mac_next     = reply_mac_reg;
        reply_ip_next      = reply_ip_reg;
        lookup_hit_next    = lookup_hit_reg;
        lookup_mac_next    = lookup_mac_reg;
        q_pop              = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = '0;

        case (st_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    item_next       = q_item;
                    issue_cnt_next  = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    match_mac_next  = '0;
                    action_next     = arpc_pkg::CA_NONE;
                    st_next = (q_item.is_lookup || q_item.learn) ? S_SCAN : S_OUT;
                end
            end
            S_SCAN:
            begin
                // read slot n, compare it in the next cycle
                cmp_valid_next = issue;
                cmp_idx_next   = issue_cnt_reg[IDX_W-1:0];
                if (issue)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (cmp_hit && !found_reg)
                begin
                    found_next     = 1'b1;
                    match_idx_next = cmp_idx_reg;
                    match_mac_next = rd_mac;
                end
                if (cmp_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (!issue && !cmp_valid_reg)
                begin
                    st_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (item_reg.learn)
                begin
                    if (found_reg)
                    begin
                        if (match_mac_reg == item_reg.mac)
                        begin
                            action_next = arpc_pkg::CA_MATCH_SAME;
                        end
                        else
                        begin
                            action_next = arpc_pkg::CA_MAC_CHANGED;
                            ram_we      = 1'b1;
                            ram_waddr   = match_idx_reg;
                        end
                    end
                    else if (free_found_reg)
                    begin
                        action_next = arpc_pkg::CA_INSERTED;
                        ram_we      = 1'b1;
                        ram_waddr   = free_idx_reg;
                    end
                    else
                    begin
                        // table full: slot 0 is replaced
                        action_next = arpc_pkg::CA_EVICTED;
                        ram_we      = 1'b1;
                        ram_waddr   = '0;
                    end
                end
                if (ram_we)
                begin
                    valid_next[ram_waddr] = 1'b1;
                end
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    packet_status_next = item_reg.status;
                    cache_action_next  = action_reg;
                    send_reply_next    = item_reg.reply;
                    reply_mac_next     = item_reg.reply ? item_reg.mac : '0;
                    reply_ip_next      = item_reg.reply ? item_reg.key_ip : '0;
                    lookup_hit_next    = item_reg.is_lookup && found_reg;
                    lookup_mac_next    = (item_reg.is_lookup && found_reg)
                                       ? match_mac_reg : '0;
                    st_next            = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            issue_cnt_reg <= '0;
            cmp_valid_reg <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg          <= item_next;
        action_reg        <= action_next;
        cmp_idx_reg       <= cmp_idx_next;
        found_reg         <= found_next;
        match_idx_reg     <= match_idx_next;
        match_mac_reg     <= match_mac_next;
        free_found_reg    <= free_found_next;
        free_idx_reg      <= free_idx_next;
        packet_status_reg <= packet_status_next;
        cache_action_reg  <= cache_action_next;
        send_reply_reg    <= send_reply_next;
        reply_mac_reg     <= reply_mac_next;
        reply_ip_reg      <= reply_ip_next;
        lookup_hit_reg    <= lookup_hit_next;
        lookup_mac_reg    <= lookup_mac_next;
    end

    assign out_valid     = out_valid_reg;
    assign packet_status = packet_status_reg;
    assign cache_action  = cache_action_reg;
    assign send_reply    = send_reply_reg;
    assign reply_mac     = reply_mac_reg;
    assign reply_ip      = reply_ip_reg;
    assign lookup_hit    = lookup_hit_reg;
    assign lookup_mac    = lookup_mac_reg;

    // table is never written while a scan reads it
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SCAN) |-> !ram_we)
        else $error("table write during scan");

    // a learn always leaves at least one valid entry
    a_learn_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DECIDE && item_reg.learn) |=> (valid_reg != '0))
        else $error("learn left table empty");

    // a miss reports a zero MAC
    a_miss_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !lookup_hit_reg) |-> (lookup_mac_reg == '0))
        else $error("nonzero MAC on lookup miss");

    // replies only come from accepted packets, never from lookups
    a_reply_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && send_reply_reg) |->
        (packet_status_reg == arpc_pkg::PS_OK && !lookup_hit_reg))
        else $error("reply raised on dropped packet or lookup");

endmodule
